[sv/assert_macros.svh]
// assertion macros included by the rtl file float32_add_sub_mul_unit
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// property holds each cycle out of reset
`define ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// antecedent implies consequent in the next cycle
`define ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);
`endif

[sv/f32u_pkg.sv]
// ----------------------------------------------------------------------------
// f32u_pkg
// shared types and constants of the float32 add/sub/mul unit
// ----------------------------------------------------------------------------
package f32u_pkg;
  localparam logic [1:0] OP_ADD = 2'd0;
  localparam logic [1:0] OP_SUB = 2'd1;
  localparam logic [1:0] OP_MUL = 2'd2;
  localparam int EXP_BIAS = 127;

  typedef struct packed {
    logic [31:0] bits;
    logic        flag;
  } res_t;

  // pack sign, signed exponent and mantissa with clamping
  function automatic res_t pack_result(logic sign, logic signed [10:0] e, logic [22:0] f);
    res_t r;
    if (e > 11'sd255) begin
      r.bits = {sign, 8'hff, f};
      r.flag = 1'b1;
    end else if (e < 11'sd0) begin
      r.bits = {sign, 31'd0};
      r.flag = 1'b1;
    end else begin
      r.bits = {sign, e[7:0], f};
      r.flag = 1'b0;
    end
    return r;
  endfunction
endpackage

[sv/float32_add_sub_mul_unit.sv]
// ----------------------------------------------------------------------------
// float32_add_sub_mul_unit
// single-precision add, subtract and multiply, truncating, no specials
// ----------------------------------------------------------------------------
// One transaction per cycle while the skid stage is empty: an input register, one
// pass of adder or multiplier logic, and an output register with a skid stage.
// An accepted transaction moves from the input register through the logic into
// the output register, which drives out_tvalid; output stalls are absorbed by
// the skid stage, and in_tready drops only while it is full. The 24x24 multiply
// sets the critical path.
module float32_add_sub_mul_unit (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [71:0] in_tdata,   // opcode[1:0], a_bits[33:2], b_bits[65:34], zero pad
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [39:0] out_tdata   // result_bits[31:0], range_flag[32], zero pad
);
  `include "assert_macros.svh"

  logic        s1_v_r;
  logic [1:0]  op_r;
  logic [31:0] a_r, b_r;
  logic        ov_r, sk_v_r;
  f32u_pkg::res_t o_r, sk_r, add_res, mul_res, res;
  logic        adv;

  f32u_add u_add (.a(a_r), .b(op_r == f32u_pkg::OP_SUB ? {~b_r[31], b_r[30:0]} : b_r),
                  .res(add_res));
  f32u_mul u_mul (.a(a_r), .b(b_r), .res(mul_res));

  assign res = op_r[1] ? mul_res : add_res;
  assign in_tready = !sk_v_r;
  assign adv = !sk_v_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
      ov_r <= 1'b0;
      sk_v_r <= 1'b0;
    end else begin
      if (adv) begin
        s1_v_r <= in_tvalid;
        op_r <= in_tdata[1:0];
        a_r <= in_tdata[33:2];
        b_r <= in_tdata[65:34];
      end
      if (ov_r && !out_tready) begin
        if (adv && s1_v_r) begin
          sk_v_r <= 1'b1;
          sk_r <= res;
        end
      end else begin
        if (sk_v_r) begin
          o_r <= sk_r;
          ov_r <= 1'b1;
          sk_v_r <= 1'b0;
        end else begin
          o_r <= res;
          ov_r <= s1_v_r;
        end
      end
    end
  end

  assign out_tvalid = ov_r;
  assign out_tdata = {7'd0, o_r.flag, o_r.bits};

  `ASSERT_ALWAYS(a_skid_full, !sk_v_r || ov_r, "skid holds data with empty output")
  `ASSERT_NEXT(a_skid_drain, sk_v_r && out_tready, ov_r && !sk_v_r, "skid did not drain")
  `ASSERT_NEXT(a_stall_hold, ov_r && !out_tready, ov_r, "output dropped while stalled")
endmodule

[sv/f32u_add.sv]
// ----------------------------------------------------------------------------
// f32u_add
// truncating single-precision adder, combinational
// ----------------------------------------------------------------------------
module f32u_add (
  input  logic [31:0]     a,
  input  logic [31:0]     b,
  output f32u_pkg::res_t  res
);
  logic               sa, sb, swap;
  logic [7:0]         ea, eb, d;
  logic [23:0]        fa, fb, big, sml;
  logic [24:0]        sum;
  logic [23:0]        diff, norm;
  logic [4:0]         lz;
  logic signed [10:0] e;
  logic               sign;

  always_comb begin
    sa = a[31];
    sb = b[31];
    ea = a[30:23];
    eb = b[30:23];
    fa = {1'b1, a[22:0]};
    fb = {1'b1, b[22:0]};
    swap = (eb > ea) || ((eb == ea) && (sa != sb) && (fb > fa));
    big = swap ? fb : fa;
    d = swap ? (eb - ea) : (ea - eb);
    sml = (d >= 8'd25) ? 24'd0 : ((swap ? fa : fb) >> d[4:0]);
    e = {3'b000, (swap ? eb : ea)};
    sign = swap ? sb : sa;
    sum = {1'b0, big} + {1'b0, sml};
    diff = big - sml;
    lz = 5'd0;
    for (int i = 23; i >= 0; i--) begin
      if (diff[i] && lz == 5'd0 && (diff >> (i + 1)) == 24'd0) lz = 5'(23 - i);
    end
    norm = diff << lz;
    if (a[30:0] == 31'd0 && b[30:0] == 31'd0) begin
      res.bits = a;
      res.flag = 1'b0;
    end else if (sa == sb) begin
      if (sum[24]) res = f32u_pkg::pack_result(sign, e + 11'sd1, sum[23:1]);
      else         res = f32u_pkg::pack_result(sign, e, sum[22:0]);
    end else if (diff == 24'd0) begin
      res.bits = 32'd0;
      res.flag = 1'b0;
    end else begin
      res = f32u_pkg::pack_result(sign, e - 11'(lz), norm[22:0]);
    end
  end
endmodule

[sv/f32u_mul.sv]
// ----------------------------------------------------------------------------
// f32u_mul
// truncating single-precision multiplier, combinational
// ----------------------------------------------------------------------------
module f32u_mul (
  input  logic [31:0]     a,
  input  logic [31:0]     b,
  output f32u_pkg::res_t  res
);
  logic [47:0]        prod;
  logic signed [10:0] e;
  logic               sign;

  always_comb begin
    sign = a[31] ^ b[31];
    prod = {1'b1, a[22:0]} * {1'b1, b[22:0]};
    e = 11'(a[30:23]) + 11'(b[30:23]) - 11'(f32u_pkg::EXP_BIAS);
    if (prod[47]) res = f32u_pkg::pack_result(sign, e + 11'sd1, prod[46:24]);
    else          res = f32u_pkg::pack_result(sign, e, prod[45:23]);
  end
endmodule

[tb/sv/float32_add_sub_mul_unit_tb.sv]
// ----------------------------------------------------------------------------
// float32_add_sub_mul_unit_tb
// drives add, subtract and multiply transactions through the unit with random
// gaps on both sides and compares each result word and range flag against a
// truncating single-precision model kept in this file
// ----------------------------------------------------------------------------
module float32_add_sub_mul_unit_tb;
  typedef struct packed {
    logic [1:0]  op;
    logic [31:0] a;
    logic [31:0] b;
  } fop_t;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [71:0] in_tdata;
  logic        out_tvalid;
  logic        out_tready;
  logic [39:0] out_tdata;

  fop_t        pending_ops[$];
  logic [32:0] expected_words[$];
  int          errors = 0;
  bit          stim_done = 0;
  bit          calm = 0;
  int          in_gap = 0;
  int          out_gap = 0;

  float32_add_sub_mul_unit uut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata)
  );

  initial begin
    clk = 0;
    forever #2 clk = ~clk;
  end

  function automatic logic [32:0] pack_word(logic s, int e, logic [23:0] f);
    if (e > 255) return {1'b1, s, 8'hff, f[22:0]};
    if (e < 0) return {1'b1, s, 31'd0};
    return {1'b0, s, e[7:0], f[22:0]};
  endfunction

  function automatic logic [23:0] align(logic [23:0] x, int d);
    if (d >= 25) return 24'd0;
    return x >> d;
  endfunction

  function automatic logic [32:0] float_sum(logic [31:0] a, logic [31:0] b);
    logic sa, sb, s;
    int ea, eb, e;
    logic [24:0] fa, fb, f;
    sa = a[31]; sb = b[31];
    ea = a[30:23]; eb = b[30:23];
    fa = {2'b01, a[22:0]}; fb = {2'b01, b[22:0]};
    if (a[30:0] == 0 && b[30:0] == 0) return {1'b0, a};
    if (sa == sb) begin
      s = sa;
      if (eb > ea) begin
        e = eb; fa = align(fa[23:0], eb - ea);
      end else begin
        e = ea; fb = align(fb[23:0], ea - eb);
      end
      f = fa + fb;
      if (f[24]) begin
        e++; f = f >> 1;
      end
    end else begin
      if (eb > ea) begin
        s = sb; e = eb; f = fb - align(fa[23:0], eb - ea);
      end else if (ea > eb) begin
        s = sa; e = ea; f = fa - align(fb[23:0], ea - eb);
      end else begin
        e = ea;
        if (fa >= fb) begin
          s = sa; f = fa - fb;
        end else begin
          s = sb; f = fb - fa;
        end
      end
      if (f == 0) return 33'd0;
      for (int i = 0; i < 23; i++) begin
        if (f[23]) break;
        f = f << 1; e--;
      end
    end
    return pack_word(s, e, f[23:0]);
  endfunction

  function automatic logic [32:0] float_result(fop_t t);
    logic [47:0] p;
    logic [24:0] f;
    int e;
    if (t.op[1]) begin
      p = {24'd0, 1'b1, t.a[22:0]} * {24'd0, 1'b1, t.b[22:0]};
      f = p[47:23];
      e = int'(t.a[30:23]) + int'(t.b[30:23]) - f32u_pkg::EXP_BIAS;
      if (f[24]) begin
        e++; f = f >> 1;
      end
      return pack_word(t.a[31] ^ t.b[31], e, f[23:0]);
    end
    if (t.op == f32u_pkg::OP_SUB) return float_sum(t.a, {~t.b[31], t.b[30:0]});
    return float_sum(t.a, t.b);
  endfunction

  function automatic logic [31:0] rand_float();
    case ($urandom_range(0, 5))
      0: return {$urandom_range(0, 1) ? 1'b1 : 1'b0, 8'd0, 23'd0};
      1: return {$urandom_range(0, 1) ? 1'b1 : 1'b0, $urandom_range(0, 1) ? 8'hff : 8'h00,
                 23'($urandom)};
      2: return {$urandom_range(0, 1) ? 1'b1 : 1'b0, 8'($urandom_range(100, 155)),
                 23'($urandom)};
      default: return $urandom;
    endcase
  endfunction

  task automatic add_op(logic [1:0] op, logic [31:0] a, logic [31:0] b);
    fop_t t;
    t.op = op; t.a = a; t.b = b;
    pending_ops.push_back(t);
  endtask

  // driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 0;
    end else begin
      if (in_tvalid && in_tready) begin
        expected_words.push_back(float_result(fop_t'({in_tdata[1:0], in_tdata[33:2],
                                                      in_tdata[65:34]})));
      end
      if (!in_tvalid || in_tready) begin
        if (in_gap > 0) begin
          in_gap--;
          in_tvalid <= 0;
        end else if (!calm && $urandom_range(0, 7) == 0) begin
          in_gap = $urandom_range(1, 5);
          in_tvalid <= 0;
        end else if (pending_ops.size() > 0) begin
          fop_t t;
          t = pending_ops.pop_front();
          in_tdata <= {6'd0, t.b, t.a, t.op};
          in_tvalid <= 1;
        end else begin
          in_tvalid <= 0;
          stim_done = 1;
        end
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 0;
    end else begin
      if (out_tvalid && out_tready) begin
        if (expected_words.size() == 0) begin
          $display("%0t unexpected result %h", $time, out_tdata[32:0]);
          errors++;
        end else begin
          logic [32:0] exp_w;
          exp_w = expected_words.pop_front();
          if (out_tdata[31:0] !== exp_w[31:0]) begin
            $display("%0t result_bits expected %h actual %h", $time, exp_w[31:0],
                     out_tdata[31:0]);
            errors++;
          end
          if (out_tdata[32] !== exp_w[32]) begin
            $display("%0t range_flag expected %b actual %b", $time, exp_w[32], out_tdata[32]);
            errors++;
          end
        end
      end
      if (out_gap > 0) begin
        out_gap--;
        out_tready <= 0;
      end else if (!calm && $urandom_range(0, 7) == 0) begin
        out_gap = $urandom_range(1, 5);
        out_tready <= 0;
      end else begin
        out_tready <= 1;
      end
    end
  end

  initial begin
    logic [31:0] x;
    rst_n = 0;
    in_tvalid = 0;
    in_tdata = '0;
    out_tready = 0;
    add_op(f32u_pkg::OP_ADD, 32'h0000_0000, 32'h8000_0000);
    add_op(f32u_pkg::OP_SUB, 32'h8000_0000, 32'h0000_0000);
    add_op(f32u_pkg::OP_ADD, 32'h3f80_0000, 32'hbf80_0000);
    add_op(f32u_pkg::OP_SUB, 32'h4040_0000, 32'h4040_0000);
    add_op(f32u_pkg::OP_ADD, 32'h3f80_0000, 32'h3f80_0000);
    add_op(f32u_pkg::OP_ADD, 32'h7fff_ffff, 32'h7fff_ffff);
    add_op(f32u_pkg::OP_ADD, 32'h4b00_0000, 32'h3f80_0000);
    add_op(f32u_pkg::OP_ADD, 32'h4c00_0000, 32'h3f80_0000);
    add_op(f32u_pkg::OP_SUB, 32'h3f80_0001, 32'h3f80_0000);
    add_op(f32u_pkg::OP_SUB, 32'h0000_0001, 32'h0000_0000);
    add_op(f32u_pkg::OP_ADD, 32'hffff_ffff, 32'h0000_0000);
    add_op(f32u_pkg::OP_SUB, 32'h0080_0000, 32'h3f80_0000);
    add_op(f32u_pkg::OP_MUL, 32'h7f80_0000, 32'h7f80_0000);
    add_op(f32u_pkg::OP_MUL, 32'h0000_0000, 32'h8000_0000);
    add_op(f32u_pkg::OP_MUL, 32'hffff_ffff, 32'h7fff_ffff);
    add_op(f32u_pkg::OP_MUL, 32'h3fff_ffff, 32'h3fff_ffff);
    add_op(f32u_pkg::OP_MUL, 32'h3f80_0000, 32'hbf80_0000);
    add_op(2'd3, 32'h4000_0000, 32'hc040_0000);
    add_op(2'd3, 32'hffff_ffff, 32'hffff_ffff);
    repeat (1350) begin
      x = rand_float();
      if ($urandom_range(0, 4) == 0)
        add_op(2'($urandom_range(0, 3)), x, {$urandom_range(0, 1) ? 1'b1 : 1'b0, x[30:0]});
      else
        add_op(2'($urandom_range(0, 3)), x, rand_float());
    end
    repeat (7) @(posedge clk);
    rst_n <= 1;
    wait (pending_ops.size() < 200);
    calm = 1;
    wait (stim_done && expected_words.size() == 0);
    repeat (10) @(posedge clk);
    if (errors == 0 && expected_words.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  initial begin
    #200000;
    $display("FAIL");
    $finish;
  end
endmodule
